@@ hw/rtl/segment_intersection_unit_macros.svh @@
// assertion macros for the segment intersection unit
// used by the checker bound to the top level
`ifndef SEGMENT_INTERSECTION_UNIT_MACROS_SVH
`define SEGMENT_INTERSECTION_UNIT_MACROS_SVH
// clocked assertion, disabled while the active-low reset is low
`define SIU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// same, on the unit's own clock and reset names
`define SIU_CHECK(lbl, prop, msg) `SIU_ASSERT(lbl, i_clk, i_rst_n, prop, msg)
`endif

@@ hw/rtl/siu_pkg.sv @@
// shared types, constants and output saturation for the segment intersection unit
// no dependencies
package siu_pkg;

    localparam int QBITS   = 33;
    localparam int OUT_W   = 32;
    localparam int LATENCY = 8 + QBITS;

    localparam logic [OUT_W-1:0] MAX_POS = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] MAX_NEG = 32'h8000_0000;

    typedef struct packed {
        logic hit;
        logic zero;
        logic neg_x;
        logic neg_y;
    } t_siu_ctl;

    localparam int CTL_W = $bits(t_siu_ctl);

    function automatic logic [OUT_W-1:0] siu_sat(input logic [QBITS-1:0] q,
                                                 input logic neg, input logic ovf);
        logic [OUT_W-1:0] res;
        if (neg) begin
            if (ovf || q > {1'b0, MAX_NEG}) begin
                res = MAX_NEG;
            end else begin
                res = OUT_W'(0) - q[OUT_W-1:0];
            end
        end else begin
            if (ovf || q > {1'b0, MAX_POS}) begin
                res = MAX_POS;
            end else begin
                res = q[OUT_W-1:0];
            end
        end
        return res;
    endfunction

endpackage

@@ hw/rtl/siu_front.sv @@
// front end: orientation tests, determinant and crossing numerators in five stages
// depends on siu_pkg
module siu_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    input  logic signed [COORD_BITS-1:0] i_cx,
    input  logic signed [COORD_BITS-1:0] i_cy,
    input  logic signed [COORD_BITS-1:0] i_ex,
    input  logic signed [COORD_BITS-1:0] i_ey,
    output logic                        o_valid,
    output siu_pkg::t_siu_ctl           o_ctl,
    output logic [3*COORD_BITS+2:0]     o_mag_x,
    output logic [3*COORD_BITS+2:0]     o_mag_y,
    output logic [2*COORD_BITS+2:0]     o_mag_d
);

    localparam int C    = COORD_BITS;
    localparam int DFW  = C + 1;
    localparam int PW   = 2 * C + 2;
    localparam int QW   = 2 * C;
    localparam int P1W  = 2 * C + 1;
    localparam int DENW = 2 * C + 3;
    localparam int NPW  = 3 * C + 2;
    localparam int NW   = 3 * C + 3;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    logic signed [C-1:0]   r_ax, r_ay, r_bx, r_by, r_cx, r_cy, r_ex, r_ey;
    logic signed [DFW-1:0] r_abx, r_aby, r_cdx, r_cdy;
    logic signed [DFW-1:0] r_bax, r_bay, r_eax, r_eay, r_cax, r_cay;
    logic signed [DFW-1:0] r_ecx, r_ecy, r_acx, r_acy, r_bcx, r_bcy;

    logic signed [PW-1:0]  r_m0, r_m1, r_m2, r_m3, r_m4, r_m5, r_m6, r_m7;
    logic signed [PW-1:0]  r_d1, r_d2;
    logic signed [QW-1:0]  r_q1a, r_q1b, r_q2a, r_q2b;
    logic signed [DFW-1:0] r2_abx, r2_aby, r2_cdx, r2_cdy;

    logic                  r3_hit;
    logic signed [DENW-1:0] r3_den;
    logic signed [P1W-1:0] r3_p1, r3_p2;
    logic signed [DFW-1:0] r3_abx, r3_aby, r3_cdx, r3_cdy;

    logic                  r4_hit;
    logic signed [DENW-1:0] r4_den;
    logic signed [NPW-1:0] r4_n0, r4_n1, r4_n2, r4_n3;

    siu_pkg::t_siu_ctl     r_ctl;
    logic [NW-1:0]         r_mx, r_my;
    logic [DENW-1:0]       r_md;

    logic                  ccw1, ccw2, ccw3, ccw4;
    logic signed [NW-1:0]  num_x, num_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // stage 1: coordinate differences
    always_ff @(posedge i_clk) begin
        r_ax  <= i_ax;
        r_ay  <= i_ay;
        r_bx  <= i_bx;
        r_by  <= i_by;
        r_cx  <= i_cx;
        r_cy  <= i_cy;
        r_ex  <= i_ex;
        r_ey  <= i_ey;
        r_abx <= DFW'(i_ax) - DFW'(i_bx);
        r_aby <= DFW'(i_ay) - DFW'(i_by);
        r_cdx <= DFW'(i_cx) - DFW'(i_ex);
        r_cdy <= DFW'(i_cy) - DFW'(i_ey);
        r_bax <= DFW'(i_bx) - DFW'(i_ax);
        r_bay <= DFW'(i_by) - DFW'(i_ay);
        r_eax <= DFW'(i_ex) - DFW'(i_ax);
        r_eay <= DFW'(i_ey) - DFW'(i_ay);
        r_cax <= DFW'(i_cx) - DFW'(i_ax);
        r_cay <= DFW'(i_cy) - DFW'(i_ay);
        r_ecx <= DFW'(i_ex) - DFW'(i_cx);
        r_ecy <= DFW'(i_ey) - DFW'(i_cy);
        r_acx <= DFW'(i_ax) - DFW'(i_cx);
        r_acy <= DFW'(i_ay) - DFW'(i_cy);
        r_bcx <= DFW'(i_bx) - DFW'(i_cx);
        r_bcy <= DFW'(i_by) - DFW'(i_cy);
    end

    // stage 2: cross products
    always_ff @(posedge i_clk) begin
        r_m0   <= PW'(r_bax) * PW'(r_eay);
        r_m1   <= PW'(r_bay) * PW'(r_eax);
        r_m2   <= PW'(r_bax) * PW'(r_cay);
        r_m3   <= PW'(r_bay) * PW'(r_cax);
        r_m4   <= PW'(r_ecx) * PW'(r_acy);
        r_m5   <= PW'(r_ecy) * PW'(r_acx);
        r_m6   <= PW'(r_ecx) * PW'(r_bcy);
        r_m7   <= PW'(r_ecy) * PW'(r_bcx);
        r_d1   <= PW'(r_abx) * PW'(r_cdy);
        r_d2   <= PW'(r_aby) * PW'(r_cdx);
        r_q1a  <= QW'(r_ax) * QW'(r_by);
        r_q1b  <= QW'(r_ay) * QW'(r_bx);
        r_q2a  <= QW'(r_cx) * QW'(r_ey);
        r_q2b  <= QW'(r_cy) * QW'(r_ex);
        r2_abx <= r_abx;
        r2_aby <= r_aby;
        r2_cdx <= r_cdx;
        r2_cdy <= r_cdy;
    end

    // orientation signs, zero counts as not counter-clockwise
    always_comb begin
        ccw1 = (DENW'(r_m0) - DENW'(r_m1)) > DENW'(0);
        ccw2 = (DENW'(r_m2) - DENW'(r_m3)) > DENW'(0);
        ccw3 = (DENW'(r_m4) - DENW'(r_m5)) > DENW'(0);
        ccw4 = (DENW'(r_m6) - DENW'(r_m7)) > DENW'(0);
    end

    // stage 3: crossing test, determinant, line constants
    always_ff @(posedge i_clk) begin
        r3_hit <= (ccw1 != ccw2) && (ccw3 != ccw4);
        r3_den <= DENW'(r_d1) - DENW'(r_d2);
        r3_p1  <= P1W'(r_q1a) - P1W'(r_q1b);
        r3_p2  <= P1W'(r_q2a) - P1W'(r_q2b);
        r3_abx <= r2_abx;
        r3_aby <= r2_aby;
        r3_cdx <= r2_cdx;
        r3_cdy <= r2_cdy;
    end

    // stage 4: numerator products
    always_ff @(posedge i_clk) begin
        r4_hit <= r3_hit;
        r4_den <= r3_den;
        r4_n0  <= NPW'(r3_p1) * NPW'(r3_cdx);
        r4_n1  <= NPW'(r3_abx) * NPW'(r3_p2);
        r4_n2  <= NPW'(r3_p1) * NPW'(r3_cdy);
        r4_n3  <= NPW'(r3_aby) * NPW'(r3_p2);
    end

    always_comb begin
        num_x = NW'(r4_n0) - NW'(r4_n1);
        num_y = NW'(r4_n2) - NW'(r4_n3);
    end

    // stage 5: signs and magnitudes for the divider
    always_ff @(posedge i_clk) begin
        r_ctl.hit   <= r4_hit;
        r_ctl.zero  <= !r4_hit || (r4_den == DENW'(0));
        r_ctl.neg_x <= num_x[NW-1] ^ r4_den[DENW-1];
        r_ctl.neg_y <= num_y[NW-1] ^ r4_den[DENW-1];
        r_mx        <= num_x[NW-1] ? NW'(-num_x) : NW'(num_x);
        r_my        <= num_y[NW-1] ? NW'(-num_y) : NW'(num_y);
        r_md        <= r4_den[DENW-1] ? DENW'(-r4_den) : DENW'(r4_den);
    end

    assign o_valid = r_v5;
    assign o_ctl   = r_ctl;
    assign o_mag_x = r_mx;
    assign o_mag_y = r_my;
    assign o_mag_d = r_md;

endmodule

@@ hw/rtl/siu_queue.sv @@
// two-word queue between the front end and the divider back end
// depends on nothing
module siu_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_count;
    logic             do_pop;

    assign do_pop  = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            r_count <= r_count + (AW+1)'(i_push) - (AW+1)'(do_pop);
        end
    end

endmodule

@@ hw/rtl/siu_back.sv @@
// back end: pipelined restoring divider, one quotient bit per stage, and saturation
// depends on siu_pkg
module siu_back #(
    parameter int NW        = 51,
    parameter int DW        = 35,
    parameter int FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  siu_pkg::t_siu_ctl               i_ctl,
    input  logic [NW-1:0]                   i_mag_x,
    input  logic [NW-1:0]                   i_mag_y,
    input  logic [DW-1:0]                   i_mag_d,
    output logic                            o_strobe,
    output logic                            o_hit,
    output logic signed [siu_pkg::OUT_W-1:0] o_cross_x,
    output logic signed [siu_pkg::OUT_W-1:0] o_cross_y
);

    localparam int QB  = siu_pkg::QBITS;
    localparam int NSW = NW + FRAC_BITS;
    localparam int EW  = NSW + QB;
    localparam int CW  = (NSW > DW) ? NSW : DW;

    logic              r_v   [QB+1];
    siu_pkg::t_siu_ctl r_ctl [QB+1];
    logic [DW-1:0]     r_d   [QB+1];
    logic [DW-1:0]     r_rx  [QB+1];
    logic [DW-1:0]     r_ry  [QB+1];
    logic [QB-1:0]     r_wx  [QB+1];
    logic [QB-1:0]     r_wy  [QB+1];
    logic              r_ovx [QB+1];
    logic              r_ovy [QB+1];

    logic [EW-1:0]     ext_x, ext_y;
    logic [CW-1:0]     hi_x, hi_y;

    logic                             r_strobe, r_hit;
    logic [siu_pkg::OUT_W-1:0]        r_x, r_y;

    always_comb begin
        ext_x = EW'(NSW'(i_mag_x) << FRAC_BITS);
        ext_y = EW'(NSW'(i_mag_y) << FRAC_BITS);
        hi_x  = CW'(ext_x >> QB);
        hi_y  = CW'(ext_y >> QB);
    end

    // entry stage: overflow check and initial remainder
    always_ff @(posedge i_clk) begin
        r_ctl[0] <= i_ctl;
        r_d[0]   <= i_mag_d;
        r_ovx[0] <= hi_x >= CW'(i_mag_d);
        r_ovy[0] <= hi_y >= CW'(i_mag_d);
        r_rx[0]  <= hi_x[DW-1:0];
        r_ry[0]  <= hi_y[DW-1:0];
        r_wx[0]  <= ext_x[QB-1:0];
        r_wy[0]  <= ext_y[QB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_stage
        logic [DW:0] tx, ty;
        logic        gx, gy;

        always_comb begin
            tx = {r_rx[k-1], r_wx[k-1][QB-1]};
            ty = {r_ry[k-1], r_wy[k-1][QB-1]};
            gx = tx >= {1'b0, r_d[k-1]};
            gy = ty >= {1'b0, r_d[k-1]};
        end

        always_ff @(posedge i_clk) begin
            r_ctl[k] <= r_ctl[k-1];
            r_d[k]   <= r_d[k-1];
            r_ovx[k] <= r_ovx[k-1];
            r_ovy[k] <= r_ovy[k-1];
            r_rx[k]  <= gx ? DW'(tx - {1'b0, r_d[k-1]}) : DW'(tx);
            r_ry[k]  <= gy ? DW'(ty - {1'b0, r_d[k-1]}) : DW'(ty);
            r_wx[k]  <= {r_wx[k-1][QB-2:0], gx};
            r_wy[k]  <= {r_wy[k-1][QB-2:0], gy};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        r_hit <= r_ctl[QB].hit;
        if (r_ctl[QB].zero) begin
            r_x <= '0;
            r_y <= '0;
        end else begin
            r_x <= siu_pkg::siu_sat(r_wx[QB], r_ctl[QB].neg_x, r_ovx[QB]);
            r_y <= siu_pkg::siu_sat(r_wy[QB], r_ctl[QB].neg_y, r_ovy[QB]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_v[QB];
        end
    end

    assign o_strobe  = r_strobe;
    assign o_hit     = r_hit;
    assign o_cross_x = r_x;
    assign o_cross_y = r_y;

endmodule

@@ hw/rtl/segment_intersection_unit.sv @@
// segment intersection unit top level: front end, queue and divider back end
// depends on siu_pkg, siu_front, siu_queue, siu_back
// A new segment pair is taken every clock cycle (busy stays low); its result word passes
// five front stages for orientation tests, determinant and numerators, the queue
// register, the divider entry stage, one stage per quotient bit of the 33-bit restoring
// divider, and the output register before it appears on o_strobe. Results cannot be held
// off; o_hit flags a proper crossing, and o_cross_x/o_cross_y give the crossing in
// Q(32-FRAC_BITS).FRAC_BITS, toward zero, saturated, zero when there is no crossing
// or the determinant is zero.
module segment_intersection_unit #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [COORD_BITS-1:0]     i_ax,
    input  logic signed [COORD_BITS-1:0]     i_ay,
    input  logic signed [COORD_BITS-1:0]     i_bx,
    input  logic signed [COORD_BITS-1:0]     i_by,
    input  logic signed [COORD_BITS-1:0]     i_cx,
    input  logic signed [COORD_BITS-1:0]     i_cy,
    input  logic signed [COORD_BITS-1:0]     i_ex,
    input  logic signed [COORD_BITS-1:0]     i_ey,
    output logic                             o_strobe,
    output logic                             o_hit,
    output logic signed [siu_pkg::OUT_W-1:0] o_cross_x,
    output logic signed [siu_pkg::OUT_W-1:0] o_cross_y
);

    localparam int NW = 3 * COORD_BITS + 3;
    localparam int DW = 2 * COORD_BITS + 3;
    localparam int CT = siu_pkg::CTL_W;
    localparam int QW = CT + 2 * NW + DW;

    logic              f_valid, q_valid;
    siu_pkg::t_siu_ctl f_ctl;
    logic [NW-1:0]     f_mx, f_my;
    logic [DW-1:0]     f_md;
    logic [QW-1:0]     q_data;

    assign busy = 1'b0;

    siu_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_ax    (i_ax),
        .i_ay    (i_ay),
        .i_bx    (i_bx),
        .i_by    (i_by),
        .i_cx    (i_cx),
        .i_cy    (i_cy),
        .i_ex    (i_ex),
        .i_ey    (i_ey),
        .o_valid (f_valid),
        .o_ctl   (f_ctl),
        .o_mag_x (f_mx),
        .o_mag_y (f_my),
        .o_mag_d (f_md)
    );

    siu_queue #(
        .WIDTH(QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  ({f_ctl, f_mx, f_my, f_md}),
        .i_pop   (1'b1),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    siu_back #(
        .NW        (NW),
        .DW        (DW),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .i_ctl     (siu_pkg::t_siu_ctl'(q_data[QW-1 -: CT])),
        .i_mag_x   (q_data[QW-CT-1 -: NW]),
        .i_mag_y   (q_data[QW-CT-NW-1 -: NW]),
        .i_mag_d   (q_data[DW-1:0]),
        .o_strobe  (o_strobe),
        .o_hit     (o_hit),
        .o_cross_x (o_cross_x),
        .o_cross_y (o_cross_y)
    );

endmodule

@@ hw/rtl/siu_checker.sv @@
// port-level checks for the segment intersection unit, bound to the top level
// depends on siu_pkg and segment_intersection_unit_macros.svh
`include "segment_intersection_unit_macros.svh"

module siu_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             o_strobe,
    input logic                             o_hit,
    input logic signed [siu_pkg::OUT_W-1:0] o_cross_x,
    input logic signed [siu_pkg::OUT_W-1:0] o_cross_y
);

    logic point_zero;

    assign point_zero = (o_cross_x == '0) && (o_cross_y == '0);

    // every word accepted comes out after the fixed latency
    `SIU_CHECK(a_word_out, (start && !busy) |-> ##(siu_pkg::LATENCY) o_strobe, "word lost")
    // no result word without an accepted word
    `SIU_CHECK(a_word_in, o_strobe |-> $past(start && !busy, siu_pkg::LATENCY), "stray word")
    // no crossing means a zero point
    `SIU_CHECK(a_miss_zero, (o_strobe && !o_hit) |-> point_zero, "miss not zero")
    `SIU_CHECK(a_never_busy, !busy, "busy raised")

endmodule

bind segment_intersection_unit siu_checker u_siu_checker (.*);

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// testbench for segment_intersection_unit: drives segment pairs and checks crossing words
// depends on siu_pkg and the segment_intersection_unit rtl
module tb;

    localparam int CB   = 16;
    localparam int FRAC = 16;
    localparam int LAT  = siu_pkg::LATENCY;

    typedef logic signed [CB-1:0] t_coord;

    typedef struct {
        logic                             hit;
        logic signed [siu_pkg::OUT_W-1:0] x;
        logic signed [siu_pkg::OUT_W-1:0] y;
    } t_crossing;

    logic   i_clk;
    logic   i_rst_n;
    logic   start;
    logic   busy;
    t_coord i_ax, i_ay, i_bx, i_by, i_cx, i_cy, i_ex, i_ey;
    logic   o_strobe;
    logic   o_hit;
    logic signed [siu_pkg::OUT_W-1:0] o_cross_x, o_cross_y;

    t_crossing pending_crossings[$];
    int        error_count;
    int        words_sent;
    int        words_checked;
    int        hits_seen;
    int        idle_pct;

    segment_intersection_unit #(.COORD_BITS(CB), .FRAC_BITS(FRAC)) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_ax      (i_ax),
        .i_ay      (i_ay),
        .i_bx      (i_bx),
        .i_by      (i_by),
        .i_cx      (i_cx),
        .i_cy      (i_cy),
        .i_ex      (i_ex),
        .i_ey      (i_ey),
        .o_strobe  (o_strobe),
        .o_hit     (o_hit),
        .o_cross_x (o_cross_x),
        .o_cross_y (o_cross_y)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d words outstanding", pending_crossings.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic bit is_ccw(input longint px, input longint py, input longint qx,
                                  input longint qy, input longint rx, input longint ry);
        return (qx - px) * (ry - py) - (qy - py) * (rx - px) > 0;
    endfunction

    function automatic logic signed [siu_pkg::OUT_W-1:0] quot_q16(
        input logic signed [127:0] num,
        input logic signed [127:0] den);
        logic signed [127:0] q;
        q = (num <<< FRAC) / den;
        if (q > 128'sh7FFF_FFFF) return siu_pkg::MAX_POS;
        if (q < -128'sh8000_0000) return siu_pkg::MAX_NEG;
        return q[siu_pkg::OUT_W-1:0];
    endfunction

    function automatic t_crossing predict_crossing(input t_coord ax, input t_coord ay,
                                                   input t_coord bx, input t_coord by,
                                                   input t_coord cx, input t_coord cy,
                                                   input t_coord ex, input t_coord ey);
        t_crossing r;
        longint abx, aby, cdx, cdy, den, p1, p2;
        logic signed [127:0] w_p1, w_p2, w_abx, w_aby, w_cdx, w_cdy, w_den;
        r.hit = (is_ccw(ax, ay, bx, by, ex, ey) != is_ccw(ax, ay, bx, by, cx, cy)) &&
                (is_ccw(cx, cy, ex, ey, ax, ay) != is_ccw(cx, cy, ex, ey, bx, by));
        r.x = '0;
        r.y = '0;
        abx = longint'(ax) - bx;
        aby = longint'(ay) - by;
        cdx = longint'(cx) - ex;
        cdy = longint'(cy) - ey;
        den = abx * cdy - aby * cdx;
        if (r.hit && den != 0) begin
            p1 = longint'(ax) * by - longint'(ay) * bx;
            p2 = longint'(cx) * ey - longint'(cy) * ex;
            w_p1  = p1;
            w_p2  = p2;
            w_abx = abx;
            w_aby = aby;
            w_cdx = cdx;
            w_cdy = cdy;
            w_den = den;
            r.x = quot_q16(w_p1 * w_cdx - w_abx * w_p2, w_den);
            r.y = quot_q16(w_p1 * w_cdy - w_aby * w_p2, w_den);
        end
        return r;
    endfunction

    // predict on every accepted word
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            pending_crossings.push_back(predict_crossing(i_ax, i_ay, i_bx, i_by,
                                                         i_cx, i_cy, i_ex, i_ey));
        end
    end

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("mismatch on %s at %0t: got %0d, expected %0d", field, $realtime, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_crossing want;
        if (i_rst_n && o_strobe) begin
            if (pending_crossings.size() == 0) begin
                report_mismatch("strobe", 1, 0);
            end else begin
                want = pending_crossings.pop_front();
                words_checked++;
                if (o_hit) hits_seen++;
                if (o_hit !== want.hit) report_mismatch("hit", o_hit, want.hit);
                if (o_cross_x !== want.x) report_mismatch("cross_x", o_cross_x, want.x);
                if (o_cross_y !== want.y) report_mismatch("cross_y", o_cross_y, want.y);
            end
        end
    end

    // start is left high after the word; the caller or next call lowers it for gaps
    task automatic send_pair(input t_coord ax, input t_coord ay, input t_coord bx,
                             input t_coord by, input t_coord cx, input t_coord cy,
                             input t_coord ex, input t_coord ey);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_ax <= ax;
        i_ay <= ay;
        i_bx <= bx;
        i_by <= by;
        i_cx <= cx;
        i_cy <= cy;
        i_ex <= ex;
        i_ey <= ey;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        words_sent++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_crossings.size() != 0) @(posedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);
    endtask

    function automatic t_coord rand_coord(input int span);
        if (span <= 0) return t_coord'($urandom());
        return t_coord'($urandom_range(2 * span) - span);
    endfunction

    function automatic t_coord rand_extreme();
        case ($urandom_range(4))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return 16'sh0001;
        endcase
    endfunction

    task automatic test_directed();
        idle_pct = 0;
        send_pair(-10, 0, 10, 0, 0, -10, 0, 10);
        send_pair(0, 0, 10, 10, 0, 10, 10, 0);
        send_pair(0, 0, 3, 7, 5, 0, 0, 9);
        send_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        send_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
        send_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767);
        send_pair(0, 0, 10, 0, 0, 5, 10, 5);
        send_pair(0, 0, 10, 0, 5, 0, 15, 0);
        send_pair(0, 0, 10, 0, 5, 0, 5, 10);
        send_pair(0, 0, 10, 0, 5, -5, 5, 0);
        send_pair(0, 0, 10, 0, 10, 0, 10, 10);
        send_pair(0, 0, 10, 10, 10, 10, 20, 0);
        send_pair(1, 1, 1, 1, 0, 0, 2, 2);
        send_pair(0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
        send_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        send_pair(-1, -1, 1, 1, -1, 1, 1, -1);
        send_pair(0, 0, 3, 1, 0, 1, 3, 0);
        send_pair(-7, 3, 11, -5, 2, -9, -4, 13);
        send_pair(32767, 0, -32768, 0, 0, 32767, 0, -32768);
        send_pair(0, 0, 5, 0, 5, -1, 5, 1);
        drain_results();
    endtask

    task automatic test_random(input int count, input int pct);
        t_coord ax, ay, bx, by, cx, cy, ex, ey;
        int span;
        idle_pct = pct;
        repeat (count) begin
            case ($urandom_range(9))
                0, 1, 2, 3: span = 100;
                4:          span = 3;
                5, 6:       span = 0;
                default:    span = $urandom_range(32767, 1);
            endcase
            ax = rand_coord(span);
            ay = rand_coord(span);
            bx = rand_coord(span);
            by = rand_coord(span);
            cx = rand_coord(span);
            cy = rand_coord(span);
            ex = rand_coord(span);
            ey = rand_coord(span);
            case ($urandom_range(9))
                0: begin
                    ax = rand_extreme();
                    by = rand_extreme();
                    cx = rand_extreme();
                    ey = rand_extreme();
                end
                1: begin
                    cx = bx;
                    cy = by;
                end
                2: begin
                    // swap ends so the pair straddles more often
                    cx = -ax;
                    ex = -bx;
                    cy = by;
                    ey = ay;
                end
                default: ;
            endcase
            send_pair(ax, ay, bx, by, cx, cy, ex, ey);
        end
        drain_results();
    endtask

    initial begin
        error_count   = 0;
        words_sent    = 0;
        words_checked = 0;
        hits_seen     = 0;
        idle_pct      = 0;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_ax    <= '0;
        i_ay    <= '0;
        i_bx    <= '0;
        i_by    <= '0;
        i_cx    <= '0;
        i_cy    <= '0;
        i_ex    <= '0;
        i_ey    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(620, 18);
        test_random(620, 70);
        test_random(620, 0);
        $display("sent %0d segment pairs, checked %0d words, %0d of them crossings",
                 words_sent, words_checked, hits_seen);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ segment_intersection_unit.f @@
+incdir+hw/rtl
hw/rtl/siu_pkg.sv
hw/rtl/siu_front.sv
hw/rtl/siu_queue.sv
hw/rtl/siu_back.sv
hw/rtl/segment_intersection_unit.sv
hw/rtl/siu_checker.sv
sim/tb.sv
